// ===== sv/elb_pkg.sv =====
package elb_pkg;

	localparam int SIZE_BITS = 16;
	localparam int DIV_W     = 2 * SIZE_BITS;
	localparam int CNT_W     = $clog2(SIZE_BITS + 1);
	localparam int HUND_W    = 14;
	localparam int SECS_W    = 17;
	localparam int HNUM_W    = SIZE_BITS + HUND_W;
	localparam int PCT_W     = SIZE_BITS + 7;

	localparam logic [HUND_W-1:0]    HUND_FULL   = 14'd10000;
	localparam logic [6:0]           NEAR_PCT    = 7'd85;
	localparam logic [6:0]           FULL_PCT    = 7'd100;
	localparam logic [SIZE_BITS-1:0] TOTAL_RESET = 16'd1024;
	localparam logic [SIZE_BITS-1:0] RATE_RESET  = 16'd64;

	localparam logic [1:0] ACT_ADD  = 2'd0;
	localparam logic [1:0] ACT_WAIT = 2'd1;

	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_RATE  = 1'b1;

	typedef struct packed {
		logic [1:0]           action;
		logic [SIZE_BITS-1:0] amount;
	} elb_in_t;

	typedef struct packed {
		logic                 dropped;
		logic                 expanded_now;
		logic [SIZE_BITS-1:0] fill_level;
		logic [SIZE_BITS-1:0] current_capacity;
		logic [HUND_W-1:0]    fill_hundredths;
		logic [SECS_W-1:0]    seconds_to_empty;
		logic                 near_full;
		logic [SIZE_BITS-1:0] advised_wait;
	} elb_out_t;

	typedef enum logic [1:0] {
		DOP_SECS = 2'd0,
		DOP_ADV  = 2'd1,
		DOP_HUND = 2'd2
	} elb_div_op_t;

	typedef struct packed {
		logic        load_in;
		logic        mul;
		logic        upd;
		logic        prep;
		logic        div_start;
		elb_div_op_t div_op;
		logic        cap_secs;
		logic        cap_adv;
		logic        cap_hund;
		logic        load_out;
	} elb_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} elb_status_t;

endpackage

// ===== sv/elb_div.sv =====
module elb_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [elb_pkg::SIZE_BITS-1:0] divisor,
	input  logic [elb_pkg::SIZE_BITS-1:0] rem_init,
	input  logic [elb_pkg::DIV_W-1:0]     dividend,
	input  logic [elb_pkg::CNT_W-1:0]     iters,
	output logic                          done,
	output logic [elb_pkg::DIV_W-1:0]     quotient
);
	import elb_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SIZE_BITS-1:0] rem_q;
	logic [SIZE_BITS-1:0] div_q;
	logic [DIV_W-1:0]     sh_q;
	logic [SIZE_BITS:0]   trial;
	logic [SIZE_BITS:0]   diff;
	logic                 ge;

	// One restoring step a cycle; quotient bits shift in behind the dividend bits.
	assign trial = {rem_q, sh_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			sh_q  <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SIZE_BITS-1:0] : trial[SIZE_BITS-1:0];
			sh_q  <= {sh_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

// ===== sv/elb_dp.sv =====
module elb_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  elb_pkg::elb_cmd_t             cmd,
	output elb_pkg::elb_status_t          status,
	input  elb_pkg::elb_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output elb_pkg::elb_out_t             out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [elb_pkg::SIZE_BITS-1:0] cfg_data
);
	import elb_pkg::*;

	logic [SIZE_BITS-1:0] total_q;
	logic [SIZE_BITS-1:0] rate_q;
	logic [SIZE_BITS-1:0] fill_q;
	logic [SIZE_BITS-1:0] cap_q;
	logic [1:0]           action_q;
	logic [SIZE_BITS-1:0] amount_q;
	logic [DIV_W-1:0]     prod_q;
	logic                 dropped_q;
	logic                 grew_q;
	logic [HNUM_W-1:0]    hnum_q;
	logic                 near_q;
	logic                 adv_ok_q;
	logic [SIZE_BITS-1:0] halfdiff_q;
	logic [SECS_W-1:0]    secs_q;
	logic [SIZE_BITS-1:0] adv_q;
	logic [HUND_W-1:0]    hund_q;
	logic                 out_valid_q;
	elb_out_t             out_q;

	logic [SIZE_BITS-1:0] room;
	logic [SIZE_BITS-1:0] troom;
	logic [SIZE_BITS:0]   sum;
	logic [SIZE_BITS-1:0] half_total;
	logic [SIZE_BITS-1:0] half_cap;
	logic [SIZE_BITS-1:0] nf_add;
	logic [SIZE_BITS-1:0] nf_add_dr;
	logic [SIZE_BITS-1:0] nf_wait;
	logic                 fits_base;
	logic                 fits_total;
	logic                 near;

	logic [SIZE_BITS-1:0] div_divisor;
	logic [SIZE_BITS-1:0] div_rem0;
	logic [DIV_W-1:0]     div_dividend;
	logic [CNT_W-1:0]     div_iters;
	logic                 div_done;
	logic [DIV_W-1:0]     div_quot;

	// Configuration registers; a zero leak rate is refused.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
			rate_q  <= RATE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOTAL: total_q <= cfg_data;
				REG_RATE: begin
					if (cfg_data != '0) begin
						rate_q <= cfg_data;
					end
				end
				default: ;
			endcase
		end
	end

	assign room       = (cap_q > fill_q) ? cap_q - fill_q : '0;
	assign troom      = (total_q > fill_q) ? total_q - fill_q : '0;
	assign sum        = {1'b0, fill_q} + {1'b0, amount_q};
	assign fits_base  = amount_q <= room;
	assign fits_total = amount_q <= troom;
	assign nf_add     = (fits_base || fits_total) ? sum[SIZE_BITS-1:0] : fill_q;
	assign nf_add_dr  = (rate_q >= nf_add) ? '0 : nf_add - rate_q;
	assign nf_wait    = (prod_q >= DIV_W'(fill_q)) ? '0 : fill_q - prod_q[SIZE_BITS-1:0];
	assign half_total = total_q >> 1;
	assign half_cap   = cap_q >> 1;
	assign near       = (PCT_W'(fill_q) * PCT_W'(FULL_PCT)) >= (PCT_W'(cap_q) * PCT_W'(NEAR_PCT));

	// Bucket state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cap_q  <= TOTAL_RESET >> 1;
		end else if (cmd.upd) begin
			case (action_q)
				ACT_ADD: begin
					fill_q <= nf_add_dr;
					if (!fits_base && fits_total) begin
						cap_q <= total_q;
					end
				end
				ACT_WAIT: begin
					fill_q <= nf_wait;
					// Shrink back to the base only while expanded.
					if (nf_wait < half_total && cap_q > half_total) begin
						cap_q <= half_total;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			action_q <= in_data.action;
			amount_q <= in_data.amount;
		end
		if (cmd.mul) begin
			prod_q <= DIV_W'(rate_q) * DIV_W'(amount_q);
		end
		if (cmd.upd) begin
			dropped_q <= (action_q == ACT_ADD) && !fits_base && !fits_total;
			grew_q    <= (action_q == ACT_ADD) && !fits_base && fits_total;
		end
		if (cmd.prep) begin
			hnum_q     <= HNUM_W'(fill_q) * HNUM_W'(HUND_FULL);
			near_q     <= near;
			adv_ok_q   <= near && (fill_q >= half_cap);
			halfdiff_q <= fill_q - half_cap;
		end
		if (cmd.cap_secs) begin
			secs_q <= (fill_q == '0) ? '0
				: SECS_W'(div_quot[SIZE_BITS-1:0]) + SECS_W'(1);
		end
		if (cmd.cap_adv) begin
			adv_q <= adv_ok_q ? div_quot[SIZE_BITS-1:0] : '0;
		end
		if (cmd.cap_hund) begin
			if (cap_q == '0) begin
				hund_q <= (fill_q != '0) ? HUND_FULL : '0;
			end else if (fill_q >= cap_q) begin
				hund_q <= HUND_FULL;
			end else begin
				hund_q <= div_quot[HUND_W-1:0];
			end
		end
	end

	// Operand selection for the shared divider. The percentage quotient is
	// below 2^HUND_W whenever it is used, so only its low bits are iterated.
	always_comb begin
		case (cmd.div_op)
			DOP_ADV: begin
				div_divisor  = rate_q;
				div_rem0     = '0;
				div_dividend = {halfdiff_q, {SIZE_BITS{1'b0}}};
				div_iters    = CNT_W'(SIZE_BITS);
			end
			DOP_HUND: begin
				div_divisor  = cap_q;
				div_rem0     = hnum_q[HNUM_W-1:HUND_W];
				div_dividend = {hnum_q[HUND_W-1:0], {(DIV_W-HUND_W){1'b0}}};
				div_iters    = CNT_W'(HUND_W);
			end
			default: begin
				div_divisor  = rate_q;
				div_rem0     = '0;
				div_dividend = {fill_q, {SIZE_BITS{1'b0}}};
				div_iters    = CNT_W'(SIZE_BITS);
			end
		endcase
	end

	elb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (div_divisor),
		.rem_init (div_rem0),
		.dividend (div_dividend),
		.iters    (div_iters),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Output register: holds a finished item until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.dropped          <= dropped_q;
			out_q.expanded_now     <= grew_q;
			out_q.fill_level       <= fill_q;
			out_q.current_capacity <= cap_q;
			out_q.fill_hundredths  <= hund_q;
			out_q.seconds_to_empty <= secs_q;
			out_q.near_full        <= near_q;
			out_q.advised_wait     <= adv_q;
		end
	end

	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

// ===== sv/elb_ctrl.sv =====
module elb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  elb_pkg::elb_status_t status,
	output elb_pkg::elb_cmd_t    cmd
);
	import elb_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_MUL      = 11'b000_0000_0010,
		ST_UPD      = 11'b000_0000_0100,
		ST_PREP     = 11'b000_0000_1000,
		ST_SECS_GO  = 11'b000_0001_0000,
		ST_SECS_RUN = 11'b000_0010_0000,
		ST_ADV_GO   = 11'b000_0100_0000,
		ST_ADV_RUN  = 11'b000_1000_0000,
		ST_HUND_GO  = 11'b001_0000_0000,
		ST_HUND_RUN = 11'b010_0000_0000,
		ST_DONE     = 11'b100_0000_0000
	} elb_state_t;

	elb_state_t state_q;
	elb_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.div_op = DOP_SECS;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd   = 1'b1;
				state_nxt = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep  = 1'b1;
				state_nxt = ST_SECS_GO;
			end
			ST_SECS_GO: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_SECS_RUN;
			end
			ST_SECS_RUN: begin
				if (status.div_done) begin
					cmd.cap_secs = 1'b1;
					state_nxt    = ST_ADV_GO;
				end
			end
			ST_ADV_GO: begin
				cmd.div_op    = DOP_ADV;
				cmd.div_start = 1'b1;
				state_nxt     = ST_ADV_RUN;
			end
			ST_ADV_RUN: begin
				cmd.div_op = DOP_ADV;
				if (status.div_done) begin
					cmd.cap_adv = 1'b1;
					state_nxt   = ST_HUND_GO;
				end
			end
			ST_HUND_GO: begin
				cmd.div_op    = DOP_HUND;
				cmd.div_start = 1'b1;
				state_nxt     = ST_HUND_RUN;
			end
			ST_HUND_RUN: begin
				cmd.div_op = DOP_HUND;
				if (status.div_done) begin
					cmd.cap_hund = 1'b1;
					state_nxt    = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

// ===== sv/expandable_leaky_bucket_core.sv =====
// A finished result waits to enter the output register while the previous result
// has not yet been taken; a new item is accepted only after the last one's result is loaded there.
// Each item takes three passes through the shared
// one-bit-per-cycle divider (16, 16 and 14 steps) plus the update sequence.
// Reset (arst_n low): fill 0, capacity 512, total capacity 1024, leak rate 64.
module expandable_leaky_bucket_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  elb_pkg::elb_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output elb_pkg::elb_out_t             out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [elb_pkg::SIZE_BITS-1:0] cfg_data
);
	import elb_pkg::*;

	elb_cmd_t    cmd;
	elb_status_t status;

	elb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	elb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
